// File: sv/lseg_pkg.sv
// Shared types, constants and the color wheel for the LED strip effect generator.
// No dependencies; compile first.
package lseg_pkg;

    localparam int PIX_W   = 6;
    localparam int COL_W   = 8;
    localparam int FRAME_W = 11;
    localparam int ADDR_W  = 8;

    // Effect modes, as written to the mode register.
    typedef enum logic [2:0] {
        MODE_SOLID         = 3'd0,
        MODE_RAINBOW       = 3'd1,
        MODE_RAINBOW_CHASE = 3'd2,
        MODE_CHASE         = 3'd3,
        MODE_WIPE          = 3'd4,
        MODE_SCANNER       = 3'd5,
        MODE_FADE          = 3'd6,
        MODE_ERROR         = 3'd7
    } t_mode;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_MODE  = 8'd0;
    localparam logic [ADDR_W-1:0] REG_RED   = 8'd1;
    localparam logic [ADDR_W-1:0] REG_GREEN = 8'd2;
    localparam logic [ADDR_W-1:0] REG_BLUE  = 8'd3;

    localparam logic [COL_W-1:0] COL_MAX    = 8'd255;
    localparam logic [COL_W-1:0] WHEEL_SEG1 = 8'd85;
    localparam logic [COL_W-1:0] WHEEL_SEG2 = 8'd170;

    // Reciprocals: x/3 = (x*683)>>11 for x < 2048, x/10 = (x*205)>>11 for x < 1024.
    localparam logic [9:0]  DIV3_MUL  = 10'd683;
    localparam logic [7:0]  DIV10_MUL = 8'd205;

    localparam logic [FRAME_W-1:0] FADE_KNEE = 11'd256;

    localparam logic [FRAME_W:0] PERIOD_SOLID   = 12'd1;
    localparam logic [FRAME_W:0] PERIOD_RAINBOW = 12'd1280;
    localparam logic [FRAME_W:0] PERIOD_RCHASE  = 12'd768;
    localparam logic [FRAME_W:0] PERIOD_CHASE   = 12'd30;
    localparam logic [FRAME_W:0] PERIOD_FADE    = 12'd384;
    localparam logic [FRAME_W:0] PERIOD_ERROR   = 12'd6;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_mode mode;
        t_rgb  base;
    } t_cfg;

    // Per-frame values, fixed for all pixels of one frame.
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [9:0]         third;  // frame / 3
        logic [1:0]         phase;  // frame % 3
        logic [FRAME_W-1:0] eye;    // scanner eye start
        t_rgb               fade;
        t_rgb               dim;
    } t_frame_ctx;

    // Pixel command from the sequencer to the render stage.
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] idx;
        logic [COL_W-1:0] hue;   // idx*256/LED_COUNT
        logic [1:0]       mod3;  // idx % 3
        logic             last;
    } t_pix_cmd;

    function automatic t_rgb wheel(input logic [COL_W-1:0] p);
        logic [COL_W-1:0] q;
        logic [9:0]       t;
        t_rgb             c;
        if (p < WHEEL_SEG1) begin
            q = p;
        end else if (p < WHEEL_SEG2) begin
            q = p - WHEEL_SEG1;
        end else begin
            q = p - WHEEL_SEG2;
        end
        t = 10'(q) * 10'd3;
        if (p < WHEEL_SEG1) begin
            c.red   = t[7:0];
            c.green = COL_MAX - t[7:0];
            c.blue  = '0;
        end else if (p < WHEEL_SEG2) begin
            c.red   = COL_MAX - t[7:0];
            c.green = '0;
            c.blue  = t[7:0];
        end else begin
            c.red   = '0;
            c.green = t[7:0];
            c.blue  = COL_MAX - t[7:0];
        end
        return c;
    endfunction

endpackage

// File: sv/lseg_if.sv
// Valid/ready channel interfaces: frame request, pixel result, config write.
// Depends on lseg_pkg.
interface lseg_req_if;
    logic valid;
    logic ready;
    logic hold_frame;

    modport source (output valid, output hold_frame, input ready);
    modport sink   (input valid, input hold_frame, output ready);
endinterface

interface lseg_pix_if;
    import lseg_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_index;
    logic [COL_W-1:0] pixel_red;
    logic [COL_W-1:0] pixel_green;
    logic [COL_W-1:0] pixel_blue;
    logic             frame_end;

    modport source (output valid, output pixel_index, output pixel_red, output pixel_green,
                    output pixel_blue, output frame_end, input ready);
    modport sink   (input valid, input pixel_index, input pixel_red, input pixel_green,
                    input pixel_blue, input frame_end, output ready);
endinterface

interface lseg_cfg_if;
    import lseg_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr;
    logic [COL_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: sv/lseg_frame_seq.sv
// Frame sequencer: takes frame requests, keeps the frame counter, walks the pixels.
// Depends on lseg_pkg and lseg_if.
module lseg_frame_seq #(
    parameter int LED_COUNT = 60
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lseg_req_if.sink              i_req,
    input  lseg_pkg::t_cfg        i_cfg_regs,
    input  logic                  i_mode_wr,
    input  logic                  i_cmd_ready,
    output lseg_pkg::t_pix_cmd    o_cmd,
    output lseg_pkg::t_frame_ctx  o_ctx
);
    import lseg_pkg::*;

    localparam logic [PIX_W-1:0]   LAST_IDX  = PIX_W'(LED_COUNT - 1);
    localparam logic [COL_W-1:0]   HUE_STEP  = COL_W'(256 / LED_COUNT);
    localparam logic [PIX_W:0]     HUE_REM   = (PIX_W + 1)'(256 % LED_COUNT);
    localparam logic [PIX_W:0]     LED_N     = (PIX_W + 1)'(LED_COUNT);
    localparam logic [FRAME_W:0]   PER_WIPE  = (FRAME_W + 1)'(LED_COUNT + 1);
    localparam logic [FRAME_W:0]   PER_SCAN  = (FRAME_W + 1)'(2 * LED_COUNT - 8);
    localparam logic [FRAME_W-1:0] EYE_TURN  = FRAME_W'(LED_COUNT - 4);
    localparam logic [FRAME_W-1:0] EYE_SPAN  = FRAME_W'(2 * LED_COUNT - 8);

    logic               r_busy;
    logic [PIX_W-1:0]   r_idx;
    logic [COL_W-1:0]   r_hue;
    logic [PIX_W:0]     r_rem;
    logic [1:0]         r_mod3;
    logic [FRAME_W-1:0] r_count;
    t_frame_ctx         r_ctx;

    t_frame_ctx         n_ctx;
    logic [FRAME_W-1:0] n_count;
    logic [FRAME_W:0]   count_inc;
    logic [FRAME_W:0]   period;
    logic [PIX_W:0]     rem_sum;
    logic [21:0]        third_prod;
    logic [COL_W-1:0]   fade_k;
    logic [18:0]        dim_r, dim_g, dim_b;
    logic [15:0]        fade_r, fade_g, fade_b;
    logic               issue, last, accept;

    assign last   = (r_idx == LAST_IDX);
    assign issue  = r_busy && i_cmd_ready;
    assign i_req.ready = !r_busy || (issue && last);
    assign accept = i_req.valid && i_req.ready;

    always_comb begin
        case (i_cfg_regs.mode)
            MODE_SOLID:         period = PERIOD_SOLID;
            MODE_RAINBOW:       period = PERIOD_RAINBOW;
            MODE_RAINBOW_CHASE: period = PERIOD_RCHASE;
            MODE_CHASE:         period = PERIOD_CHASE;
            MODE_WIPE:          period = PER_WIPE;
            MODE_SCANNER:       period = PER_SCAN;
            MODE_FADE:          period = PERIOD_FADE;
            default:            period = PERIOD_ERROR;
        endcase
        count_inc = (FRAME_W + 1)'(r_count) + 1'b1;
        n_count   = (count_inc >= period) ? '0 : count_inc[FRAME_W-1:0];
    end

    // Per-frame context from the current count.
    always_comb begin
        third_prod  = 22'(r_count) * 22'(DIV3_MUL);
        n_ctx.frame = r_count;
        n_ctx.third = third_prod[20:11];
        n_ctx.phase = 2'(r_count - {n_ctx.third, 1'b0} - FRAME_W'(n_ctx.third));
        n_ctx.eye   = (r_count < EYE_TURN) ? r_count : EYE_SPAN - r_count;
        // falling half of fade: 255 - 2*(f-256), low byte only
        fade_k      = (r_count < FADE_KNEE) ? r_count[7:0] : COL_MAX - {r_count[6:0], 1'b0};
        fade_r      = 16'(fade_k) * 16'(i_cfg_regs.base.red);
        fade_g      = 16'(fade_k) * 16'(i_cfg_regs.base.green);
        fade_b      = 16'(fade_k) * 16'(i_cfg_regs.base.blue);
        n_ctx.fade  = '{red: fade_r[15:8], green: fade_g[15:8], blue: fade_b[15:8]};
        dim_r       = 19'(i_cfg_regs.base.red)   * 19'(DIV10_MUL);
        dim_g       = 19'(i_cfg_regs.base.green) * 19'(DIV10_MUL);
        dim_b       = 19'(i_cfg_regs.base.blue)  * 19'(DIV10_MUL);
        n_ctx.dim   = '{red: dim_r[18:11], green: dim_g[18:11], blue: dim_b[18:11]};
    end

    // hue = floor(idx*256/N), tracked as quotient and remainder
    assign rem_sum = r_rem + HUE_REM;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_hue   <= '0;
            r_rem   <= '0;
            r_mod3  <= '0;
            r_count <= '0;
        end else begin
            if (i_mode_wr) begin
                r_count <= '0;
            end else if (accept && !i_req.hold_frame) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_hue  <= '0;
                r_rem  <= '0;
                r_mod3 <= '0;
            end else if (issue) begin
                if (last) begin
                    r_busy <= 1'b0;
                end
                r_idx  <= r_idx + 1'b1;
                r_mod3 <= (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 1'b1;
                if (rem_sum >= LED_N) begin
                    r_rem <= rem_sum - LED_N;
                    r_hue <= r_hue + HUE_STEP + 1'b1;
                end else begin
                    r_rem <= rem_sum;
                    r_hue <= r_hue + HUE_STEP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctx <= n_ctx;
        end
    end

    assign o_cmd = '{valid: r_busy, idx: r_idx, hue: r_hue, mod3: r_mod3, last: last};
    assign o_ctx = r_ctx;

endmodule

// File: sv/lseg_pix_render.sv
// Pixel render stage: color of one LED from mode, base color and frame context,
// into the output register. Depends on lseg_pkg and lseg_if.
module lseg_pix_render #(
    parameter int LED_COUNT = 60
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lseg_pkg::t_cfg        i_cfg_regs,
    input  lseg_pkg::t_frame_ctx  i_ctx,
    input  lseg_pkg::t_pix_cmd    i_cmd,
    output logic                  o_cmd_ready,
    lseg_pix_if.source            o_pix
);
    import lseg_pkg::*;

    localparam logic [FRAME_W-1:0] LED_N = FRAME_W'(LED_COUNT);

    logic             r_valid;
    logic [PIX_W-1:0] r_idx;
    t_rgb             r_rgb;
    logic             r_end;

    t_rgb             n_rgb;
    t_rgb             wheel_rgb;
    logic [COL_W-1:0] wheel_pos;
    logic [FRAME_W-1:0] chase_sum;
    logic [FRAME_W-1:0] chase_mod;
    logic [FRAME_W:0] pos12, eye12;
    logic             on_phase;
    logic             load;

    assign o_cmd_ready = !r_valid || o_pix.ready;
    assign load        = i_cmd.valid && o_cmd_ready;

    always_comb begin
        on_phase  = (i_cmd.mod3 == i_ctx.phase);
        // (idx - phase + frame/3) mod 255; only used when idx%3 == phase
        chase_sum = FRAME_W'(i_cmd.idx) - FRAME_W'(i_ctx.phase) + FRAME_W'(i_ctx.third);
        if (chase_sum >= 11'd510) begin
            chase_mod = chase_sum - 11'd510;
        end else if (chase_sum >= 11'd255) begin
            chase_mod = chase_sum - 11'd255;
        end else begin
            chase_mod = chase_sum;
        end
        wheel_pos = (i_cfg_regs.mode == MODE_RAINBOW) ? i_cmd.hue + i_ctx.frame[7:0]
                                                      : chase_mod[7:0];
        wheel_rgb = wheel(wheel_pos);
        pos12     = (FRAME_W + 1)'(i_cmd.idx);
        eye12     = (FRAME_W + 1)'(i_ctx.eye);

        n_rgb = '0;
        case (i_cfg_regs.mode)
            MODE_SOLID: n_rgb = i_cfg_regs.base;
            MODE_RAINBOW: n_rgb = wheel_rgb;
            MODE_RAINBOW_CHASE: begin
                if (on_phase) n_rgb = wheel_rgb;
            end
            MODE_CHASE: begin
                if (on_phase) n_rgb = i_cfg_regs.base;
            end
            MODE_WIPE: begin
                if (i_ctx.frame < LED_N && FRAME_W'(i_cmd.idx) <= i_ctx.frame) begin
                    n_rgb = i_cfg_regs.base;
                end
            end
            MODE_SCANNER: begin
                if (pos12 == eye12 || pos12 == eye12 + 12'd3) begin
                    n_rgb = i_ctx.dim;
                end else if (pos12 == eye12 + 12'd1 || pos12 == eye12 + 12'd2) begin
                    n_rgb = i_cfg_regs.base;
                end
            end
            MODE_FADE: n_rgb = i_ctx.fade;
            default: begin
                if (!i_ctx.frame[0]) n_rgb.red = COL_MAX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_idx <= i_cmd.idx;
            r_rgb <= n_rgb;
            r_end <= i_cmd.last;
        end
    end

    assign o_pix.valid       = r_valid;
    assign o_pix.pixel_index = r_idx;
    assign o_pix.pixel_red   = r_rgb.red;
    assign o_pix.pixel_green = r_rgb.green;
    assign o_pix.pixel_blue  = r_rgb.blue;
    assign o_pix.frame_end   = r_end;

endmodule

// File: sv/led_strip_effect_generator_top.sv
// LED strip effect generator: one frame request in, LED_COUNT pixel beats out.
// The first pixel beat passes the sequencer registers, then the render output register.
// The render stage passes one pixel per cycle while the pixel sink is ready; a new request
// is taken as the last pixel of the previous one is issued.
// Reset: mode = error flash, base color black, frame counter zero, no frame in flight.
module led_strip_effect_generator_top #(
    parameter int LED_COUNT = 60   // 5..64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lseg_req_if.sink   i_req,
    lseg_cfg_if.sink   i_cfg,
    lseg_pix_if.source o_pix
);
    import lseg_pkg::*;

    // Config registers. Writes are expected only while the block is idle,
    // so the render path reads them directly.
    t_cfg       r_cfg;
    logic       cfg_wr;
    logic       mode_wr;

    t_pix_cmd   w_cmd;
    logic       w_cmd_ready;
    t_frame_ctx w_ctx;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    // any mode write restarts the effect, even with the same value
    assign mode_wr     = cfg_wr && (i_cfg.addr == REG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_ERROR;
            r_cfg.base <= '0;
        end else if (cfg_wr) begin
            case (i_cfg.addr)
                REG_MODE:  r_cfg.mode       <= t_mode'(i_cfg.data[2:0]);
                REG_RED:   r_cfg.base.red   <= i_cfg.data;
                REG_GREEN: r_cfg.base.green <= i_cfg.data;
                REG_BLUE:  r_cfg.base.blue  <= i_cfg.data;
                default:   ;  // unmapped index, ignored
            endcase
        end
    end

    // Sequencer: latches the frame context on accept, then issues one pixel a cycle while render is ready.
    // A new request is taken in the cycle the last pixel is issued.
    lseg_frame_seq #(
        .LED_COUNT (LED_COUNT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_regs  (r_cfg),
        .i_mode_wr   (mode_wr),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd),
        .o_ctx       (w_ctx)
    );

    // Render: combinational color per pixel, registered onto the output channel.
    lseg_pix_render #(
        .LED_COUNT (LED_COUNT)
    ) u_render (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_regs  (r_cfg),
        .i_ctx       (w_ctx),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_pix       (o_pix)
    );

    // frame_end marks exactly the last LED
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.frame_end == (o_pix.pixel_index == PIX_W'(LED_COUNT - 1))))
        else $error("frame_end does not match last LED index");

    // no index beyond the strip
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.pixel_index <= PIX_W'(LED_COUNT - 1)))
        else $error("pixel index beyond strip length");

    // an issued pixel lands in the output register
    a_issue_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.valid && w_cmd_ready) |=> (o_pix.valid && o_pix.pixel_index == $past(w_cmd.idx)))
        else $error("issued pixel lost");

endmodule

// File: tb/lseg_pixel_check.sv
// Pixel stream checker for the LED strip effect generator: watches all three channels,
// predicts every LED color of each frame request and compares the pixel beats in order.
// Depends on lseg_pkg and the channel interfaces in lseg_if.sv.
module lseg_pixel_check #(
    parameter int LED_COUNT = 60
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lseg_req_if  req,
    lseg_cfg_if  cfg,
    lseg_pix_if  pix,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lseg_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] idx;
        t_rgb             rgb;
        logic             last;
    } t_led_beat;

    t_led_beat          pending_leds[$];
    t_mode              cur_mode;
    t_rgb               base_col;
    logic [FRAME_W-1:0] frame_no;

    // Three-segment wheel: a ramp of 3 per step, the other channel falling from full.
    function automatic t_rgb wheel_color(input logic [COL_W-1:0] pos);
        logic [COL_W-1:0] off;
        logic [COL_W-1:0] up;
        t_rgb             c;
        if (pos >= WHEEL_SEG2) begin
            off = pos - WHEEL_SEG2;
        end else if (pos >= WHEEL_SEG1) begin
            off = pos - WHEEL_SEG1;
        end else begin
            off = pos;
        end
        up = off * 8'd3;
        if (pos >= WHEEL_SEG2) begin
            c = '{red: '0, green: up, blue: COL_MAX - up};
        end else if (pos >= WHEEL_SEG1) begin
            c = '{red: COL_MAX - up, green: '0, blue: up};
        end else begin
            c = '{red: up, green: COL_MAX - up, blue: '0};
        end
        return c;
    endfunction

    function automatic t_rgb scale_color(input t_rgb c, input logic [COL_W-1:0] k);
        logic [2*COL_W-1:0] pr, pg, pb;
        pr = (2*COL_W)'(k) * (2*COL_W)'(c.red);
        pg = (2*COL_W)'(k) * (2*COL_W)'(c.green);
        pb = (2*COL_W)'(k) * (2*COL_W)'(c.blue);
        return '{red: pr[2*COL_W-1:COL_W], green: pg[2*COL_W-1:COL_W],
                 blue: pb[2*COL_W-1:COL_W]};
    endfunction

    function automatic int unsigned mode_period(input t_mode m);
        case (m)
            MODE_SOLID:         return PERIOD_SOLID;
            MODE_RAINBOW:       return PERIOD_RAINBOW;
            MODE_RAINBOW_CHASE: return PERIOD_RCHASE;
            MODE_CHASE:         return PERIOD_CHASE;
            MODE_WIPE:          return LED_COUNT + 1;
            MODE_SCANNER:       return 2 * LED_COUNT - 8;
            MODE_FADE:          return PERIOD_FADE;
            default:            return PERIOD_ERROR;
        endcase
    endfunction

    function automatic t_rgb led_color(input int unsigned led, input int unsigned f);
        int unsigned n;
        int unsigned q;
        int unsigned s;
        int unsigned k;
        t_rgb        dim;
        n   = LED_COUNT;
        dim = '{red: base_col.red / 8'd10, green: base_col.green / 8'd10,
                blue: base_col.blue / 8'd10};
        case (cur_mode)
            MODE_SOLID: return base_col;
            MODE_RAINBOW: return wheel_color(COL_W'((led * 256) / n + f));
            MODE_RAINBOW_CHASE: begin
                q = f % 3;
                if (led % 3 == q) return wheel_color(COL_W'(((led - q) + f / 3) % 255));
            end
            MODE_CHASE: if (led % 3 == f % 3) return base_col;
            MODE_WIPE: if (f < n && led <= f) return base_col;
            MODE_SCANNER: begin
                // eye runs up to N-4, then back down to 1
                s = (f < n - 4) ? f : (2 * n - 8) - f;
                if (led == s || led == s + 3) return dim;
                if (led == s + 1 || led == s + 2) return base_col;
            end
            MODE_FADE: begin
                k = (f < 256) ? f : 255 - 2 * (f - 256);
                return scale_color(base_col, COL_W'(k));
            end
            default: if (f % 2 == 0) return '{red: COL_MAX, green: '0, blue: '0};
        endcase
        return '0;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        o_fail_count = o_fail_count + 1;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : watch
        t_led_beat want;
        if (!i_rst_n) begin
            pending_leds.delete();
            cur_mode = MODE_ERROR;
            base_col = '0;
            frame_no = '0;
        end else begin
            if (pix.valid && pix.ready) begin
                if (pending_leds.size() == 0) begin
                    flag_mismatch($sformatf("unexpected pixel beat, led %0d", pix.pixel_index));
                end else begin
                    want = pending_leds.pop_front();
                    if (pix.pixel_index !== want.idx)
                        flag_mismatch($sformatf("pixel_index got %0d want %0d",
                                                pix.pixel_index, want.idx));
                    if (pix.pixel_red !== want.rgb.red)
                        flag_mismatch($sformatf("led %0d red got %0d want %0d",
                                                want.idx, pix.pixel_red, want.rgb.red));
                    if (pix.pixel_green !== want.rgb.green)
                        flag_mismatch($sformatf("led %0d green got %0d want %0d",
                                                want.idx, pix.pixel_green, want.rgb.green));
                    if (pix.pixel_blue !== want.rgb.blue)
                        flag_mismatch($sformatf("led %0d blue got %0d want %0d",
                                                want.idx, pix.pixel_blue, want.rgb.blue));
                    if (pix.frame_end !== want.last)
                        flag_mismatch($sformatf("led %0d frame_end got %0b want %0b",
                                                want.idx, pix.frame_end, want.last));
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.addr)
                    REG_MODE: begin
                        cur_mode = t_mode'(cfg.data[2:0]);
                        frame_no = '0;
                    end
                    REG_RED:   base_col.red   = cfg.data;
                    REG_GREEN: base_col.green = cfg.data;
                    REG_BLUE:  base_col.blue  = cfg.data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready) begin
                for (int led = 0; led < LED_COUNT; led++) begin
                    pending_leds.push_back('{idx: PIX_W'(led), rgb: led_color(led, frame_no),
                                             last: (led == LED_COUNT - 1)});
                end
                if (!req.hold_frame)
                    frame_no = (frame_no + 1 >= mode_period(cur_mode)) ? '0
                                                                      : FRAME_W'(frame_no + 1);
            end
        end
        o_pending <= pending_leds.size();
    end

endmodule

// File: tb/tb_top.sv
// Top of the LED strip effect generator testbench: clock, reset, frame requests,
// register writes and pixel back-pressure; verdict from the pixel checker's counts.
// Depends on lseg_pkg, lseg_if.sv, the generator RTL and lseg_pixel_check.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lseg_pkg::*;

    localparam int LED_COUNT      = 60;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int IDLE_PCT       = 38;    // percent of cycles a side sits idle
    localparam int HOLDOFF_CYCLES = 400;   // long pixel stall, several frames' worth
    localparam int NOISE_PHASES   = 2;
    localparam int FRAME_CAP      = LED_COUNT;  // cap on frames per mode in the period runs

    // Indexes outside the register map; writes there must be ignored.
    localparam logic [ADDR_W-1:0] REG_JUNK_LO = REG_BLUE + 8'd1;
    localparam logic [ADDR_W-1:0] REG_JUNK_HI = '1;

    logic    clk;
    logic    rst_n;
    bit      steady;          // no idling on either side while set
    int      holdoff_asked;   // bumped by the stimulus to request one long pixel stall
    int      fails;
    int      pending;
    longint  cycles;

    lseg_req_if req_ch ();
    lseg_cfg_if cfg_ch ();
    lseg_pix_if pix_ch ();

    led_strip_effect_generator_top #(.LED_COUNT(LED_COUNT)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_pix   (pix_ch)
    );

    lseg_pixel_check #(.LED_COUNT(LED_COUNT)) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .req          (req_ch),
        .cfg          (cfg_ch),
        .pix          (pix_ch),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    initial cycles = 0;
    always @(posedge clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Pixel sink. Random stalls, none while steady is set, and one long hold-off
    // each time the stimulus asks for it; the hold-off length is counted here.
    initial begin : pixel_sink
        int served;
        int left;
        served       = 0;
        left         = 0;
        pix_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (left == 0 && served != holdoff_asked) begin
                served = served + 1;
                left   = HOLDOFF_CYCLES;
            end
            if (left > 0) begin
                left = left - 1;
                pix_ch.ready <= 1'b0;
            end else begin
                pix_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Mostly random levels, with a fair share of the two extremes.
    function automatic logic [COL_W-1:0] pick_level();
        case ($urandom_range(3))
            0:       return '0;
            1:       return COL_MAX;
            default: return COL_W'($urandom);
        endcase
    endfunction

    // One register write beat; valid drops again right after the handshake.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [COL_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One frame request beat. Returns at the accepting edge with valid still high,
    // so back-to-back requests keep valid up without a glitch.
    task automatic send_frame(input bit hold);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.hold_frame <= hold;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Drop the request, let every predicted pixel come out, then a few spare cycles
    // so the block is surely idle before the next register write.
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_color();
        write_reg(REG_RED, pick_level());
        write_reg(REG_GREEN, pick_level());
        write_reg(REG_BLUE, pick_level());
    endtask

    initial begin : stimulus
        t_mode md;
        int    target;
        int    adv;
        int    n;
        bit    hold;
        bit    mid_done;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.hold_frame = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.addr       = '0;
        cfg_ch.data       = '0;
        steady            = 1'b0;
        holdoff_asked     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- directed ----------------
        // Out of reset: error flash, black base, frame 0. Hold in the middle
        // must re-render the same frame.
        send_frame(1'b0);
        send_frame(1'b1);
        send_frame(1'b0);
        wait_drained();

        // Writes outside the map change nothing; the flash keeps its phase.
        write_reg(REG_JUNK_HI, '1);
        write_reg(REG_JUNK_LO, '0);
        send_frame(1'b0);
        wait_drained();

        // Full white, then every mode for two frames. Upper data bits are set
        // on the mode write; only the low three count.
        write_reg(REG_RED, COL_MAX);
        write_reg(REG_GREEN, COL_MAX);
        write_reg(REG_BLUE, COL_MAX);
        md = md.first();
        do begin
            write_reg(REG_MODE, {5'b11111, md});
            send_frame(1'b0);
            send_frame(1'b0);
            wait_drained();
            md = md.next();
        end while (md != md.first());

        // Black base in solid mode.
        write_reg(REG_RED, '0);
        write_reg(REG_GREEN, '0);
        write_reg(REG_BLUE, '0);
        write_reg(REG_MODE, {5'b00000, MODE_SOLID});
        send_frame(1'b1);
        wait_drained();

        // ---------------- period runs ----------------
        // Short-period modes run past their wrap point; the long ones run for a
        // strip's worth of frames, which still turns the scanner eye around.
        // Halfway through, one color register is rewritten, which must not
        // disturb the frame counter.
        md = md.first();
        do begin
            load_color();
            write_reg(REG_MODE, {5'($urandom), md});
            // the fade run goes with no idling at all
            steady <= (md == MODE_FADE);
            // during the wipe the sink stalls long enough to back the block up
            if (md == MODE_WIPE) holdoff_asked <= holdoff_asked + 1;
            case (md)
                MODE_SOLID:         target = PERIOD_SOLID;
                MODE_RAINBOW:       target = PERIOD_RAINBOW;
                MODE_RAINBOW_CHASE: target = PERIOD_RCHASE;
                MODE_CHASE:         target = PERIOD_CHASE;
                MODE_WIPE:          target = LED_COUNT + 1;
                MODE_SCANNER:       target = 2 * LED_COUNT - 8;
                MODE_FADE:          target = PERIOD_FADE;
                default:            target = PERIOD_ERROR;
            endcase
            if (target > FRAME_CAP) target = FRAME_CAP;
            target   = target + $urandom_range(1, 4);
            adv      = 0;
            mid_done = 1'b0;
            while (adv < target) begin
                if (!mid_done && adv >= target / 2) begin
                    wait_drained();
                    write_reg(ADDR_W'($urandom_range(REG_RED, REG_BLUE)), pick_level());
                    mid_done = 1'b1;
                end
                hold = ($urandom_range(7) == 0);
                send_frame(hold);
                if (!hold) adv = adv + 1;
            end
            wait_drained();
            steady <= 1'b0;
            md = md.next();
        end while (md != md.first());

        // ---------------- noise ----------------
        // Short bursts with random register subsets (sometimes no mode write, so
        // the counter carries over), stray writes outside the map, holds at random.
        repeat (NOISE_PHASES) begin
            if ($urandom_range(1)) write_reg(REG_MODE, COL_W'($urandom));
            if ($urandom_range(1)) write_reg(REG_RED, pick_level());
            if ($urandom_range(1)) write_reg(REG_GREEN, pick_level());
            if ($urandom_range(1)) write_reg(REG_BLUE, pick_level());
            if ($urandom_range(3) == 0)
                write_reg(ADDR_W'($urandom_range(REG_JUNK_LO, REG_JUNK_HI)), COL_W'($urandom));
            n = $urandom_range(4, 12);
            repeat (n) send_frame(bit'($urandom_range(1)));
            wait_drained();
        end

        // Everything predicted has come out; a few more cycles for stray beats.
        repeat (8) @(negedge clk);
        if (fails == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: led_strip_effect_generator_top.f
sv/lseg_pkg.sv
sv/lseg_if.sv
sv/lseg_frame_seq.sv
sv/lseg_pix_render.sv
sv/led_strip_effect_generator_top.sv
tb/lseg_pixel_check.sv
tb/tb_top.sv
